[rtl/mul_div_unit_32_macros.svh]
// Assertion helpers used by mul_div_unit_32.sv.
`ifndef MUL_DIV_UNIT_32_MACROS_SVH
`define MUL_DIV_UNIT_32_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MDU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mul_div_unit_32: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define MDU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mul_div_unit_32: next-cycle check failed");

`endif

[rtl/mdu_pkg.sv]
`timescale 1ns / 1ps

package mdu_pkg;

   localparam int WORD_W = 32;
   localparam int CMD_W  = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_MULU = 2'd0,
      CMD_MULS = 2'd1,
      CMD_DIVU = 2'd2,
      CMD_DIVS = 2'd3
   } cmd_type;

endpackage

[rtl/mdu_alu.sv]
`timescale 1ns / 1ps

module mdu_alu #(
   parameter int WORD_W = mdu_pkg::WORD_W
) (
   input  logic              sub,
   input  logic [WORD_W-1:0] acc,
   input  logic              shift_in,
   input  logic [WORD_W-1:0] oper,
   output logic [WORD_W+1:0] sum
);
   import mdu_pkg::*;

   localparam int SW = WORD_W + 2;

   logic [SW-1:0] opa;
   logic [SW-1:0] opb;

   always_comb begin
      if (sub) begin
         opa = {1'b0, acc, shift_in};
         opb = ~{2'b00, oper};
      end else begin
         opa = {2'b00, acc};
         opb = {2'b00, oper};
      end
   end

   assign sum = opa + opb + {{(SW-1){1'b0}}, sub};

endmodule

[rtl/mul_div_unit_32.sv]
`timescale 1ns / 1ps
//
// Iterative multiply / divide unit.
// Request channel: req_cmd, req_operand_a_low, req_operand_a_high and
// req_operand_b are taken at a rising edge with start high and busy low.
// req_cmd 0 multiplies unsigned, 1 multiplies signed, 2 divides unsigned
// (64/32), 3 divides signed. busy stays high until the request finishes.
// Result channel: rsp_valid is high for exactly one cycle with the product
// or quotient on rsp_result_low / rsp_result_high, the remainder magnitude
// on rsp_remainder_out and rsp_ok; a zero divisor or quotient overflow
// gives rsp_ok low and zero results. The receiver cannot stall the strobe.
// One shared adder/subtractor runs one shift-add or restoring step per
// cycle, so a multiply takes 32 steps and a divide 64, after a load on
// accept and before a finish state. A new request may be started in the
// cycle the strobe is shown.
// Reset (synchronous, active high) returns the unit to idle and drops any
// request in flight without a result.
//
`include "mul_div_unit_32_macros.svh"

module mul_div_unit_32 #(
   parameter int WORD_W = mdu_pkg::WORD_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [mdu_pkg::CMD_W-1:0] req_cmd,
   input  logic [WORD_W-1:0]        req_operand_a_low,
   input  logic [WORD_W-1:0]        req_operand_a_high,
   input  logic [WORD_W-1:0]        req_operand_b,
   output logic                     busy,
   output logic                     rsp_valid,
   output logic [WORD_W-1:0]        rsp_result_low,
   output logic [WORD_W-1:0]        rsp_result_high,
   output logic [WORD_W-1:0]        rsp_remainder_out,
   output logic                     rsp_ok
);
   import mdu_pkg::*;

   localparam int DW    = 2 * WORD_W;
   localparam int CNT_W = $clog2(DW);
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(WORD_W - 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DW - 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [DW-1:0]     shreg_ff, shreg_in;
   logic [WORD_W-1:0] oper_ff, oper_in;
   logic              is_div_ff, is_div_in;
   logic              sdiv_ff, sdiv_in;
   logic              neg_ff, neg_in;
   logic              zdiv_ff, zdiv_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_low_ff, rsp_low_in;
   logic [WORD_W-1:0] rsp_high_ff, rsp_high_in;
   logic [WORD_W-1:0] rsp_rem_ff, rsp_rem_in;
   logic              rsp_ok_ff, rsp_ok_in;

   logic              accept;
   logic [WORD_W-1:0] mag_a_low;
   logic [WORD_W-1:0] mag_b;
   logic [DW-1:0]     dividend;
   logic [DW-1:0]     mag_dvd;
   logic [WORD_W+1:0] alu_sum;
   logic [WORD_W:0]   mul_step;
   logic              qbit;
   logic              last;
   logic [DW-1:0]     fin_val;
   logic [DW-1:0]     fin_neg;
   logic              fin_err;

   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);
   assign dividend = {req_operand_a_high, req_operand_a_low};

   assign mag_a_low = req_operand_a_low[WORD_W-1] ?
                      (~req_operand_a_low + WORD_W'(1)) : req_operand_a_low;
   assign mag_b     = req_operand_b[WORD_W-1] ?
                      (~req_operand_b + WORD_W'(1)) : req_operand_b;
   assign mag_dvd   = req_operand_a_high[WORD_W-1] ? (~dividend + DW'(1)) : dividend;

   mdu_alu #(
      .WORD_W(WORD_W)
   ) u_alu (
      .sub      (is_div_ff),
      .acc      (acc_ff),
      .shift_in (shreg_ff[DW-1]),
      .oper     (oper_ff),
      .sum      (alu_sum)
   );

   assign mul_step = shreg_ff[0] ? alu_sum[WORD_W:0] : {1'b0, acc_ff};
   assign qbit     = !alu_sum[WORD_W+1];
   assign last     = (cnt_ff == (is_div_ff ? DIV_LAST : MUL_LAST));

   assign fin_val = is_div_ff ? shreg_ff : {acc_ff, shreg_ff[WORD_W-1:0]};
   assign fin_neg = neg_ff ? (~fin_val + DW'(1)) : fin_val;
   assign fin_err = is_div_ff && (zdiv_ff ||
                    (sdiv_ff ? (shreg_ff[DW-1:WORD_W-1] != '0)
                             : (shreg_ff[DW-1:WORD_W] != '0)));

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      shreg_in     = shreg_ff;
      oper_in      = oper_ff;
      is_div_in    = is_div_ff;
      sdiv_in      = sdiv_ff;
      neg_in       = neg_ff;
      zdiv_in      = zdiv_ff;
      rsp_valid_in = 1'b0;
      rsp_low_in   = rsp_low_ff;
      rsp_high_in  = rsp_high_ff;
      rsp_rem_in   = rsp_rem_ff;
      rsp_ok_in    = rsp_ok_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               cnt_in   = '0;
               acc_in   = '0;
               zdiv_in  = (req_operand_b == '0);
               case (cmd_type'(req_cmd))
                  CMD_MULU: begin
                     oper_in   = req_operand_a_low;
                     shreg_in  = {{WORD_W{1'b0}}, req_operand_b};
                     is_div_in = 1'b0;
                     sdiv_in   = 1'b0;
                     neg_in    = 1'b0;
                  end
                  CMD_MULS: begin
                     oper_in   = mag_a_low;
                     shreg_in  = {{WORD_W{1'b0}}, mag_b};
                     is_div_in = 1'b0;
                     sdiv_in   = 1'b0;
                     neg_in    = req_operand_a_low[WORD_W-1] ^ req_operand_b[WORD_W-1];
                  end
                  CMD_DIVU: begin
                     oper_in   = req_operand_b;
                     shreg_in  = dividend;
                     is_div_in = 1'b1;
                     sdiv_in   = 1'b0;
                     neg_in    = 1'b0;
                  end
                  default: begin
                     oper_in   = mag_b;
                     shreg_in  = mag_dvd;
                     is_div_in = 1'b1;
                     sdiv_in   = 1'b1;
                     neg_in    = req_operand_a_high[WORD_W-1] ^ req_operand_b[WORD_W-1];
                  end
               endcase
            end
         end
         ST_RUN: begin
            if (is_div_ff) begin
               acc_in   = qbit ? alu_sum[WORD_W-1:0] : {acc_ff[WORD_W-2:0], shreg_ff[DW-1]};
               shreg_in = {shreg_ff[DW-2:0], qbit};
            end else begin
               acc_in   = mul_step[WORD_W:1];
               shreg_in = {shreg_ff[DW-1:WORD_W], mul_step[0], shreg_ff[WORD_W-1:1]};
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_ok_in    = !fin_err;
            if (fin_err) begin
               rsp_low_in  = '0;
               rsp_high_in = '0;
               rsp_rem_in  = '0;
            end else begin
               rsp_low_in  = fin_neg[WORD_W-1:0];
               rsp_high_in = fin_neg[DW-1:WORD_W];
               rsp_rem_in  = is_div_ff ? acc_ff : '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      shreg_ff    <= shreg_in;
      oper_ff     <= oper_in;
      is_div_ff   <= is_div_in;
      sdiv_ff     <= sdiv_in;
      neg_ff      <= neg_in;
      zdiv_ff     <= zdiv_in;
      rsp_low_ff  <= rsp_low_in;
      rsp_high_ff <= rsp_high_in;
      rsp_rem_ff  <= rsp_rem_in;
      rsp_ok_ff   <= rsp_ok_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_low    = rsp_low_ff;
   assign rsp_result_high   = rsp_high_ff;
   assign rsp_remainder_out = rsp_rem_ff;
   assign rsp_ok            = rsp_ok_ff;

   `MDU_ASSERT_NEXT(a_accept_runs, clock, reset, accept, (state_ff == ST_RUN) && (cnt_ff == '0))
   `MDU_ASSERT_NEXT(a_done_strobes, clock, reset, state_ff == ST_DONE, rsp_valid && !busy)
   `MDU_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid && !rsp_ok, (rsp_result_low == '0) && (rsp_result_high == '0) && (rsp_remainder_out == '0))

endmodule

[dv/mul_div_unit_32_checker.sv]
`timescale 1ns / 1ps

module mul_div_unit_32_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic [mdu_pkg::CMD_W-1:0]  req_cmd,
   input  logic [mdu_pkg::WORD_W-1:0] req_operand_a_low,
   input  logic [mdu_pkg::WORD_W-1:0] req_operand_a_high,
   input  logic [mdu_pkg::WORD_W-1:0] req_operand_b,
   input  logic                       rsp_valid,
   input  logic [mdu_pkg::WORD_W-1:0] rsp_result_low,
   input  logic [mdu_pkg::WORD_W-1:0] rsp_result_high,
   input  logic [mdu_pkg::WORD_W-1:0] rsp_remainder_out,
   input  logic                       rsp_ok,
   output int                         mismatch_count,
   output int                         outstanding,
   output int                         rejected_count
);
   import mdu_pkg::*;

   localparam logic [63:0] SIGNED_QUO_LIMIT = 64'h0000_0000_8000_0000;

   typedef struct packed {
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] rem;
      logic        ok;
   } mdu_result_type;

   mdu_result_type pending_results[$];

   function automatic logic [31:0] magnitude32(logic [31:0] v);
      return v[31] ? ~v + 32'd1 : v;
   endfunction

   function automatic mdu_result_type arith_result(cmd_type cmd, logic [31:0] a_lo,
                                                   logic [31:0] a_hi, logic [31:0] b);
      mdu_result_type r;
      logic [63:0] dividend;
      logic [63:0] wide;
      logic [63:0] quo;
      logic [63:0] remd;
      logic [63:0] nmag;
      logic [31:0] mb;
      r = '0;
      dividend = {a_hi, a_lo};
      case (cmd)
         CMD_MULU: begin
            wide = {32'd0, a_lo} * {32'd0, b};
            {r.hi, r.lo} = wide;
            r.ok = 1'b1;
         end
         CMD_MULS: begin
            wide = {32'd0, magnitude32(a_lo)} * {32'd0, magnitude32(b)};
            if (a_lo[31] ^ b[31]) wide = ~wide + 64'd1;
            {r.hi, r.lo} = wide;
            r.ok = 1'b1;
         end
         CMD_DIVU: begin
            if (b != 32'd0) begin
               quo  = dividend / {32'd0, b};
               remd = dividend % {32'd0, b};
               if (quo[63:32] == 32'd0) begin
                  r.lo  = quo[31:0];
                  r.rem = remd[31:0];
                  r.ok  = 1'b1;
               end
            end
         end
         default: begin
            if (b != 32'd0) begin
               nmag = a_hi[31] ? ~dividend + 64'd1 : dividend;
               mb   = magnitude32(b);
               quo  = nmag / {32'd0, mb};
               remd = nmag % {32'd0, mb};
               if (quo < SIGNED_QUO_LIMIT) begin
                  if (a_hi[31] ^ b[31]) quo = ~quo + 64'd1;
                  {r.hi, r.lo} = quo;
                  r.rem = remd[31:0];
                  r.ok  = 1'b1;
               end
            end
         end
      endcase
      return r;
   endfunction

   mdu_result_type want;
   int             errs;
   int             pushed;
   int             popped;

   always @(posedge clock) begin
      if (reset) begin
         mismatch_count <= 0;
         outstanding    <= 0;
         rejected_count <= 0;
         pending_results.delete();
      end else begin
         errs   = 0;
         pushed = 0;
         popped = 0;
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               $error("result strobe with no request outstanding");
               errs++;
            end else begin
               want = pending_results.pop_front();
               popped = 1;
               if (rsp_result_low !== want.lo) begin
                  $error("rsp_result_low: expected %h, got %h", want.lo, rsp_result_low);
                  errs++;
               end
               if (rsp_result_high !== want.hi) begin
                  $error("rsp_result_high: expected %h, got %h", want.hi, rsp_result_high);
                  errs++;
               end
               if (rsp_remainder_out !== want.rem) begin
                  $error("rsp_remainder_out: expected %h, got %h", want.rem,
                         rsp_remainder_out);
                  errs++;
               end
               if (rsp_ok !== want.ok) begin
                  $error("rsp_ok: expected %b, got %b", want.ok, rsp_ok);
                  errs++;
               end
               if (!want.ok) rejected_count <= rejected_count + 1;
            end
         end
         if (start && !busy) begin
            pending_results.push_back(arith_result(cmd_type'(req_cmd), req_operand_a_low,
                                                   req_operand_a_high, req_operand_b));
            pushed = 1;
         end
         mismatch_count <= mismatch_count + errs;
         outstanding    <= outstanding + pushed - popped;
      end
   end

endmodule

[dv/mul_div_unit_32_tb.sv]
`timescale 1ns / 1ps

module mul_div_unit_32_tb;
   import mdu_pkg::*;

   localparam int RANDOM_REQUESTS = 1450;
   localparam int QUIET_TAIL      = 200;
   localparam int SETTLE_CYCLES   = 80;

   logic              clock;
   logic              reset;
   logic              start;
   logic [CMD_W-1:0]  req_cmd;
   logic [WORD_W-1:0] req_operand_a_low;
   logic [WORD_W-1:0] req_operand_a_high;
   logic [WORD_W-1:0] req_operand_b;
   logic              busy;
   logic              rsp_valid;
   logic [WORD_W-1:0] rsp_result_low;
   logic [WORD_W-1:0] rsp_result_high;
   logic [WORD_W-1:0] rsp_remainder_out;
   logic              rsp_ok;
   int                mismatch_count;
   int                outstanding;
   int                rejected_count;
   int                sent_by_cmd[4];

   mul_div_unit_32 i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .req_cmd           (req_cmd),
      .req_operand_a_low (req_operand_a_low),
      .req_operand_a_high(req_operand_a_high),
      .req_operand_b     (req_operand_b),
      .busy              (busy),
      .rsp_valid         (rsp_valid),
      .rsp_result_low    (rsp_result_low),
      .rsp_result_high   (rsp_result_high),
      .rsp_remainder_out (rsp_remainder_out),
      .rsp_ok            (rsp_ok)
   );

   mul_div_unit_32_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_operand_a_low (req_operand_a_low),
      .req_operand_a_high(req_operand_a_high),
      .req_operand_b     (req_operand_b),
      .rsp_valid         (rsp_valid),
      .rsp_result_low    (rsp_result_low),
      .rsp_result_high   (rsp_result_high),
      .rsp_remainder_out (rsp_remainder_out),
      .rsp_ok            (rsp_ok),
      .mismatch_count    (mismatch_count),
      .outstanding       (outstanding),
      .rejected_count    (rejected_count)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic logic [31:0] rand_word();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 4))
               0: w = 32'h0000_0000;
               1: w = 32'h0000_0001;
               2: w = 32'hFFFF_FFFF;
               3: w = 32'h8000_0000;
               default: w = 32'h7FFF_FFFF;
            endcase
         end
         1: w = $urandom_range(0, 15);
         2: w = w >> $urandom_range(1, 31);
         3: w = ~(w >> $urandom_range(1, 31));
         default: ;
      endcase
      return w;
   endfunction

   // hold start until the request is taken
   task automatic send_request(cmd_type cmd, logic [31:0] a_lo, logic [31:0] a_hi,
                               logic [31:0] b);
      @(negedge clock);
      start              = 1'b1;
      req_cmd            = cmd;
      req_operand_a_low  = a_lo;
      req_operand_a_high = a_hi;
      req_operand_b      = b;
      do @(posedge clock); while (busy);
      sent_by_cmd[int'(cmd)]++;
   endtask

   task automatic idle_cycles(int n);
      repeat (n) begin
         @(negedge clock);
         start              = 1'b0;
         req_cmd            = CMD_W'($urandom);
         req_operand_a_low  = $urandom;
         req_operand_a_high = $urandom;
         req_operand_b      = $urandom;
      end
   endtask

   task automatic drain_results();
      idle_cycles(1);
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic send_random_request();
      cmd_type     cmd;
      logic [31:0] a_lo;
      logic [31:0] a_hi;
      logic [31:0] b;
      logic [31:0] mb;
      logic [63:0] nmag;
      cmd  = cmd_type'($urandom_range(0, 3));
      a_lo = rand_word();
      a_hi = rand_word();
      b    = rand_word();
      if (cmd == CMD_DIVU && $urandom_range(0, 9) > 1) begin
         // keep the quotient in range most of the time
         if (b == 32'd0) b = $urandom_range(1, 32'hFFFF_FFFF);
         a_hi = rand_word() % b;
      end else if (cmd == CMD_DIVS && $urandom_range(0, 9) > 1) begin
         if (b == 32'd0) b = 32'hFFFF_FFFF;
         mb   = b[31] ? ~b + 32'd1 : b;
         nmag = {32'd0, rand_word() & 32'h7FFF_FFFF} * {32'd0, mb}
                + ({32'd0, rand_word()} % {32'd0, mb});
         if ($urandom_range(0, 1)) nmag = ~nmag + 64'd1;
         {a_hi, a_lo} = nmag;
      end
      send_request(cmd, a_lo, a_hi, b);
   endtask

   initial begin
      int  gaps_on;
      reset              = 1'b1;
      start              = 1'b0;
      req_cmd            = CMD_MULU;
      req_operand_a_low  = '0;
      req_operand_a_high = '0;
      req_operand_b      = '0;
      gaps_on            = 1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_request(CMD_MULU, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(CMD_MULU, 32'hFFFF_FFFF, 32'h1234_5678, 32'hFFFF_FFFF);
      send_request(CMD_MULU, 32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(CMD_MULS, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000);
      send_request(CMD_MULS, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(CMD_MULS, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000);
      send_request(CMD_MULS, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h0000_0001);
      send_request(CMD_MULS, 32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000);
      send_request(CMD_MULS, 32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF);
      send_request(CMD_DIVU, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(CMD_DIVU, 32'h0000_0000, 32'h0000_0005, 32'h0000_0005);
      send_request(CMD_DIVU, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
      send_request(CMD_DIVU, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
      send_request(CMD_DIVU, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001);
      send_request(CMD_DIVS, 32'h1234_5678, 32'h8000_0000, 32'h0000_0000);
      send_request(CMD_DIVS, 32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
      send_request(CMD_DIVS, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
      send_request(CMD_DIVS, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0001);
      send_request(CMD_DIVS, 32'h8000_0001, 32'hFFFF_FFFF, 32'h0000_0001);
      send_request(CMD_DIVS, 32'hFFFF_FFF9, 32'hFFFF_FFFF, 32'h0000_0002);
      send_request(CMD_DIVS, 32'h0000_0007, 32'h0000_0000, 32'hFFFF_FFFE);
      send_request(CMD_DIVS, 32'hFFFF_FFF9, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
      send_request(CMD_DIVS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0005);
      send_request(CMD_DIVS, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000);
      send_request(CMD_DIVS, 32'h0000_0000, 32'hC000_0000, 32'h8000_0000);
      drain_results();

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i % 64 == 0) gaps_on = $urandom_range(0, 2) != 0;
         if (i > 0 && i % 300 == 0) drain_results();
         send_random_request();
         if (i < RANDOM_REQUESTS - QUIET_TAIL && gaps_on && $urandom_range(0, 2) == 0)
            idle_cycles($urandom_range(1, 8));
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Covered %0d unsigned mul, %0d signed mul, %0d unsigned div, %0d signed div",
               sent_by_cmd[0], sent_by_cmd[1], sent_by_cmd[2], sent_by_cmd[3]);
      $display("Divides flagged for zero divisor or overflow: %0d", rejected_count);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d requests outstanding", outstanding);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
